@@ rtl/tskf_pkg.sv @@
// Package for the three-axis scalar Kalman filter.
// Shared widths, reset values, default parameters and the divider request type.
// No dependencies.
package tskf_pkg;

  // Default top-level parameters
  localparam int DEF_AXES        = 3;
  localparam int DEF_SAMPLE_BITS = 16;
  localparam int DEF_FRAC_BITS   = 16;

  // Fixed formats: variance and noise Q8.16 in 24 bits, estimate 32 bits signed
  localparam int VAR_BITS = 24;
  localparam int DEN_W    = VAR_BITS + 1;
  localparam int EST_W    = 32;
  localparam int INNOV_W  = EST_W + 1;
  // wide enough for a sample scaled up by the largest fraction width
  localparam int WIDE_W   = 40;

  localparam logic [VAR_BITS-1:0] VAR_MAX    = {VAR_BITS{1'b1}};
  localparam logic [VAR_BITS-1:0] RST_PNOISE = 24'd655;
  localparam logic [VAR_BITS-1:0] RST_MNOISE = 24'd131072;

  // Request to the shared divider
  typedef struct packed {
    logic                start;
    logic [VAR_BITS-1:0] num;
    logic [DEN_W-1:0]    den;
  } div_req_t;

endpackage

@@ rtl/three_axis_scalar_kalman_filter_top.sv @@
// Three-axis scalar Kalman filter, top level: sequencer, state and shared multiplier.
// Depends on tskf_pkg and tskf_div.
//
// channel   dir  handshake                      contents
// s_axis    in   s_axis_tvalid / s_axis_tready  one sample per axis
// m_axis    out  m_axis_tvalid / m_axis_tready  one estimate per axis
// cfg       in   cfg_we                         process / measurement noise regs
//
// Axes are processed one after another; each includes the bit-serial gain division
// (FRAC_BITS+1 quotient steps). After the last axis the sequencer returns to idle,
// so a new word is taken only once the previous item is finished.
// s_axis_tready is high only while the sequencer is idle; a pending output word
// does not block the next input, only the final load of the output register.
// rst is synchronous: estimates go to zero, variances to 1.0, noise regs to defaults.
module three_axis_scalar_kalman_filter_top import tskf_pkg::*; #(
  parameter int AXES        = DEF_AXES,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int FRAC_BITS   = DEF_FRAC_BITS,
  localparam int IN_W       = ((AXES * SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W      = AXES * EST_W,
  localparam int CFG_IDX_W  = (2 * AXES > 1) ? $clog2(2 * AXES) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_W-1:0]      s_axis_tdata,  // sample_x, sample_y, sample_z, zero pad
  // output stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OUT_W-1:0]     m_axis_tdata,  // est_x, est_y, est_z
  // config write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAR_BITS-1:0]  cfg_data
);

  localparam int AXIS_W = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int K_W    = FRAC_BITS + 1;
  localparam int PROD_W = K_W + 1 + INNOV_W;

  localparam logic [AXIS_W-1:0]   AXIS_LAST = AXIS_W'(AXES - 1);
  localparam logic [K_W-1:0]      K_ONE     = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [VAR_BITS-1:0] VAR_ONE   = VAR_BITS'(32'd1 << FRAC_BITS);

  localparam logic signed [WIDE_W-1:0] MEAS_MAX =
    {{(WIDE_W - EST_W + 1){1'b0}}, {(EST_W - 1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] MEAS_MIN =
    {{(WIDE_W - EST_W + 1){1'b1}}, {(EST_W - 1){1'b0}}};
  localparam logic signed [PROD_W-1:0] SUM_MAX =
    {{(PROD_W - EST_W + 1){1'b0}}, {(EST_W - 1){1'b1}}};
  localparam logic signed [PROD_W-1:0] SUM_MIN =
    {{(PROD_W - EST_W + 1){1'b1}}, {(EST_W - 1){1'b0}}};

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // wait for a sample word
  localparam logic [2:0] S_PREP = 3'd1;  // predicted variance
  localparam logic [2:0] S_DEN  = 3'd2;  // denominator, innovation, start divide
  localparam logic [2:0] S_DIV  = 3'd3;  // wait for gain
  localparam logic [2:0] S_MULK = 3'd4;  // gain * innovation
  localparam logic [2:0] S_ACC  = 3'd5;  // estimate update
  localparam logic [2:0] S_MULV = 3'd6;  // (1 - gain) * variance
  localparam logic [2:0] S_WVAR = 3'd7;  // variance writeback, next axis

  logic [2:0]             state;
  logic [AXIS_W-1:0]      axis;

  logic [VAR_BITS-1:0]    pnoise   [AXES];
  logic [VAR_BITS-1:0]    mnoise   [AXES];
  logic [EST_W-1:0]       est      [AXES];
  logic [VAR_BITS-1:0]    var_q    [AXES];
  logic [SAMPLE_BITS-1:0] samp     [AXES];

  logic [VAR_BITS-1:0]    p_r;
  logic                   den_zero;
  logic signed [INNOV_W-1:0] innov_r;
  logic [K_W-1:0]         k_r;
  logic signed [PROD_W-1:0]  prod_r;

  // combinational helpers
  logic [VAR_BITS:0]      p_sum;
  logic [DEN_W-1:0]       den_c;
  logic signed [WIDE_W-1:0]  meas_w;
  logic [EST_W-1:0]       meas32;
  logic signed [K_W:0]    mul_a;
  logic signed [INNOV_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  est_ext;
  logic signed [PROD_W-1:0]  sum;
  logic [EST_W-1:0]       est_new;
  logic                   out_load;

  div_req_t               div_req;
  logic                   div_done;
  logic [K_W-1:0]         div_quot;

  assign s_axis_tready = (state == S_IDLE);

  // last axis done and the output register free
  assign out_load = (state == S_WVAR) && (axis == AXIS_LAST) &&
                    (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    p_sum  = {1'b0, var_q[axis]} + {1'b0, pnoise[axis]};
    den_c  = {1'b0, p_r} + {1'b0, mnoise[axis]};

    // sample scaled to Q.F, clamped to the estimate range
    meas_w = {{(WIDE_W - SAMPLE_BITS){samp[axis][SAMPLE_BITS-1]}}, samp[axis]};
    meas_w = meas_w <<< FRAC_BITS;
    if (meas_w > MEAS_MAX)      meas32 = MEAS_MAX[EST_W-1:0];
    else if (meas_w < MEAS_MIN) meas32 = MEAS_MIN[EST_W-1:0];
    else                        meas32 = meas_w[EST_W-1:0];

    // shared multiplier operands
    if (state == S_MULV) begin
      mul_a = {1'b0, K_ONE - k_r};
      mul_b = {{(INNOV_W - VAR_BITS){1'b0}}, p_r};
    end else begin
      mul_a = {1'b0, k_r};
      mul_b = innov_r;
    end

    // floor shift of the correction, then saturate
    est_ext = {{(PROD_W - EST_W){est[axis][EST_W-1]}}, est[axis]};
    sum     = est_ext + (prod_r >>> FRAC_BITS);
    if (sum > SUM_MAX)      est_new = SUM_MAX[EST_W-1:0];
    else if (sum < SUM_MIN) est_new = SUM_MIN[EST_W-1:0];
    else                    est_new = sum[EST_W-1:0];

    div_req.start = (state == S_DEN);
    div_req.num   = p_r;
    div_req.den   = den_c;
  end

  tskf_div #(
    .Q_W (K_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quot (div_quot)
  );

  // control, filter state and registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      axis          <= '0;
      m_axis_tvalid <= 1'b0;
      for (int a = 0; a < AXES; a++) begin
        pnoise[a] <= RST_PNOISE;
        mnoise[a] <= RST_MNOISE;
        est[a]    <= '0;
        var_q[a]  <= VAR_ONE;
      end
    end else begin
      if (out_load)                            m_axis_tvalid <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;

      if (cfg_we) begin
        for (int a = 0; a < AXES; a++) begin
          if (cfg_index == CFG_IDX_W'(a))        pnoise[a] <= cfg_data;
          if (cfg_index == CFG_IDX_W'(AXES + a)) mnoise[a] <= cfg_data;
        end
      end

      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            axis  <= '0;
            state <= S_PREP;
          end
        end
        S_PREP: state <= S_DEN;
        S_DEN:  state <= S_DIV;
        S_DIV:  if (div_done) state <= S_MULK;
        S_MULK: state <= S_ACC;
        S_ACC: begin
          est[axis] <= est_new;
          state     <= S_MULV;
        end
        S_MULV: state <= S_WVAR;
        S_WVAR: begin
          var_q[axis] <= prod_r[FRAC_BITS +: VAR_BITS];
          if (axis != AXIS_LAST) begin
            axis  <= axis + 1'b1;
            state <= S_PREP;
          end else if (out_load) begin
            state <= S_IDLE;
          end
          // otherwise hold here until the output register is free
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_axis_tvalid) begin
      for (int a = 0; a < AXES; a++) samp[a] <= s_axis_tdata[a*SAMPLE_BITS +: SAMPLE_BITS];
    end
    if (state == S_PREP) p_r <= p_sum[VAR_BITS] ? VAR_MAX : p_sum[VAR_BITS-1:0];
    if (state == S_DEN) begin
      den_zero <= (den_c == '0);
      innov_r  <= $signed({meas32[EST_W-1], meas32}) - $signed({est[axis][EST_W-1], est[axis]});
    end
    if (state == S_DIV && div_done) k_r <= den_zero ? '0 : div_quot;
    if (state == S_MULK || state == S_MULV) prod_r <= mul_a * mul_b;
    // output word; the last axis estimate is written back in S_ACC so est[] is final here
    if (out_load) begin
      for (int a = 0; a < AXES; a++) m_axis_tdata[a*EST_W +: EST_W] <= est[a];
    end
  end

`ifndef NO_ASSERTIONS
  // no second word taken while an item is in flight
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while sequencer busy");

  // divider result only arrives while the sequencer waits for it
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider done outside divide state");

  // gain never exceeds 1.0 when it is used
  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MULK) |-> (k_r <= K_ONE))
    else $error("gain above one");

  // a finished item raises the output valid on the next edge
  a_out_on_finish: assert property (@(posedge clk) disable iff (rst)
    (state == S_WVAR && axis == AXIS_LAST && !m_axis_tvalid) |=> m_axis_tvalid)
    else $error("finished item not presented");
`endif

endmodule

@@ rtl/tskf_div.sv @@
// Radix-2 restoring divider: quot = floor(num * 2^(Q_W-1) / den), one bit per cycle.
// Requires num <= den. Depends on tskf_pkg.
module tskf_div import tskf_pkg::*; #(
  parameter int Q_W = DEF_FRAC_BITS + 1
) (
  input  logic           clk,
  input  logic           rst,
  input  div_req_t       req,
  output logic           done,
  output logic [Q_W-1:0] quot
);

  localparam int CNT_W = (Q_W > 1) ? $clog2(Q_W) : 1;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(Q_W - 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   rem;
  logic [DEN_W:0]   den_r;
  logic             ge;
  logic [DEN_W:0]   rem_sub;

  always_comb begin
    ge      = (rem >= den_r);
    rem_sub = ge ? (rem - den_r) : rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem   <= {2'b00, req.num};
      den_r <= {1'b0, req.den};
      quot  <= '0;
    end else if (busy) begin
      quot <= {quot[Q_W-2:0], ge};
      rem  <= {rem_sub[DEN_W-1:0], 1'b0};
    end
  end

endmodule
